@@ src/hsfr_pkg.sv @@
// Shared types and codes for the header-synced frame ring receiver.
// Depends on nothing; imported by the receiver module (the RAM does not use it).
package hsfr_pkg;

  // Input item codes
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  // Register reset values and the minimum frame length
  localparam logic [7:0] HEADER_RESET = 8'h59;
  localparam logic [6:0] LENGTH_RESET = 7'd10;
  localparam logic [6:0] LENGTH_MIN   = 7'd3;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       frame_ready;
    logic       ring_blocked;
  } result_t;

endpackage

@@ src/hsfr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; the frame store is an instance of this module.
module hsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read into a registered output; hold data while idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/header_synced_frame_ring_receiver.sv @@
// Header-synced frame receiver: received bytes build fixed-length frames that open with two
// header bytes and land in a ring of SLOTS slots held in one RAM; a take streams the oldest
// frame out one byte per beat. A received byte, a clear, a take with no frame waiting or an
// unused kind yields one beat; the block takes such an item even while an earlier beat is
// stalled, parking its beat in a one-deep skid register, as long as that register is empty.
// A take of an n-byte frame yields n beats at one per cycle once the output flows; the RAM's
// read port sets that pace. After the take is accepted the controller enters its stream state
// and issues the first RAM read; the registered read data then loads the output register, and
// the next item is taken once the final frame byte has entered the output register.
module header_synced_frame_ring_receiver
  import hsfr_pkg::*;
#(
  parameter int SLOTS      = 4,
  parameter int SLOT_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] rx_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       frame_ready,
  output logic       ring_blocked
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = $clog2(SLOT_BYTES);
  localparam int FILL_W = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int DEPTH  = SLOTS * (2 ** IDX_W);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);
  localparam logic [6:0]        LENGTH_MAX = 7'(SLOT_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(SLOT_BYTES);

  // configuration registers
  logic [7:0] header_byte;
  logic [6:0] frame_length;
  logic       receive_enable;

  // ring bookkeeping
  logic [FILL_W-1:0] fill [SLOTS];
  logic [FILL_W-1:0] fill_next [SLOTS];
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic              full_hold, full_hold_next;

  // controller
  state_t state, state_next;
  logic   in_fire, take_go, single;
  logic   have_frame;
  kind_t  kind_c;

  // stream counters
  logic [SLOT_W-1:0] str_slot;
  logic [IDX_W-1:0]  str_idx;
  logic [FILL_W-1:0] str_left;
  logic              pend, pend_last;
  logic              issue, pend_load, out_free;

  // output and skid registers
  result_t out_res, hold_res, single_res;
  logic    hold_valid;

  // RAM ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rd_data;

  // receive path helpers
  logic [FILL_W-1:0] wfill, wfill_clamp, wfill_inc, eff_len;
  logic [6:0]        len_clamp;
  logic [SLOT_W-1:0] ws_adv, rs_adv;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  assign kind_c     = kind_t'(kind);
  assign have_frame = full_hold || (read_slot != write_slot);
  assign in_fire    = in_valid && !in_stall;
  assign take_go    = in_fire && (kind_c == KIND_TAKE) && have_frame
                      && (fill[read_slot] != '0);
  assign single     = in_fire && !take_go;
  assign out_free   = !out_valid || !out_stall;
  assign pend_load  = pend && out_free && !hold_valid;

  // Clamp the frame length and form the write-slot fill values
  always_comb begin
    if (frame_length < LENGTH_MIN) begin
      len_clamp = LENGTH_MIN;
    end else if (frame_length > LENGTH_MAX) begin
      len_clamp = LENGTH_MAX;
    end else begin
      len_clamp = frame_length;
    end
    eff_len     = FILL_W'(len_clamp);
    wfill       = fill[write_slot];
    wfill_clamp = (wfill >= FILL_MAX) ? FILL_MAX - FILL_W'(1) : wfill;
    wfill_inc   = wfill_clamp + FILL_W'(1);
    ws_adv      = next_slot(write_slot);
    rs_adv      = next_slot(read_slot);
  end

  // Update ring state for an accepted item; write the received byte
  always_comb begin
    fill_next       = fill;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    full_hold_next  = full_hold;
    wr_en           = 1'b0;
    wr_addr         = {write_slot, wfill_clamp[IDX_W-1:0]};
    if (in_fire) begin
      case (kind_c)
        KIND_BYTE: begin
          if (receive_enable && !full_hold) begin
            if ((wfill < FILL_W'(2)) && (rx_byte != header_byte)) begin
              fill_next[write_slot] = '0;
            end else begin
              wr_en                 = 1'b1;
              fill_next[write_slot] = wfill_inc;
              if (wfill_inc >= eff_len) begin
                if (ws_adv != read_slot) begin
                  write_slot_next   = ws_adv;
                  fill_next[ws_adv] = '0;
                end else begin
                  full_hold_next = 1'b1;
                end
              end
            end
          end
        end
        KIND_TAKE: begin
          if (have_frame) begin
            fill_next[read_slot] = '0;
            read_slot_next       = rs_adv;
            if (full_hold) begin
              write_slot_next   = ws_adv;
              fill_next[ws_adv] = '0;
              full_hold_next    = 1'b0;
            end
          end
        end
        KIND_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            fill_next[i] = '0;
          end
          write_slot_next = '0;
          read_slot_next  = '0;
          full_hold_next  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Beat for an item that yields a single result, seen after its update
  always_comb begin
    single_res.out_byte     = 8'd0;
    single_res.byte_valid   = 1'b0;
    single_res.last         = 1'b1;
    single_res.frame_ready  = full_hold_next || (read_slot_next != write_slot_next);
    single_res.ring_blocked = full_hold_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_go) begin
          state_next = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (pend_load && pend_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = hold_valid;
      end
      ST_STREAM: begin
        issue = (str_left != '0) && (!pend || pend_load);
      end
      default: begin
      end
    endcase
  end

  // Hold configuration, ring pointers and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte    <= HEADER_RESET;
      frame_length   <= LENGTH_RESET;
      receive_enable <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        fill[i] <= '0;
      end
      write_slot <= '0;
      read_slot  <= '0;
      full_hold  <= 1'b0;
      state      <= ST_IDLE;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HEADER: header_byte    <= cfg_data;
          REG_LENGTH: frame_length   <= cfg_data[6:0];
          REG_ENABLE: receive_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
      fill       <= fill_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      full_hold  <= full_hold_next;
      state      <= state_next;
    end
  end

  // Advance the read stream: issue one RAM read per cycle while the output drains
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue) begin
      pend <= 1'b1;
    end else if (pend_load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_go) begin
      str_slot <= read_slot;
      str_idx  <= '0;
      str_left <= fill[read_slot];
    end else if (issue) begin
      str_idx  <= str_idx + IDX_W'(1);
      str_left <= str_left - FILL_W'(1);
    end
    if (issue) begin
      pend_last <= (str_left == FILL_W'(1));
    end
  end

  // Load the output register from the skid, the RAM or a fresh single result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid <= pend_load || single;
      end
    end else if (single) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_res <= hold_res;
      end else if (pend_load) begin
        out_res.out_byte     <= rd_data;
        out_res.byte_valid   <= 1'b1;
        out_res.last         <= pend_last;
        out_res.frame_ready  <= have_frame;
        out_res.ring_blocked <= full_hold;
      end else if (single) begin
        out_res <= single_res;
      end
    end else if (single) begin
      hold_res <= single_res;
    end
  end

  assign out_byte     = out_res.out_byte;
  assign byte_valid   = out_res.byte_valid;
  assign last         = out_res.last;
  assign frame_ready  = out_res.frame_ready;
  assign ring_blocked = out_res.ring_blocked;

  // Frame store: one row of slot bytes per slot
  hsfr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(rx_byte),
    .rd_en  (issue),
    .rd_addr({str_slot, str_idx}),
    .rd_data(rd_data)
  );

endmodule
